// ----- rtl/vsd_pkg.sv -----
package vsd_pkg;

	localparam int LABEL_BITS = 4;
	localparam int PATH_BITS  = 32;
	localparam int CFG_BITS   = 5;
	localparam logic [CFG_BITS-1:0] LABEL_COUNT_RESET = 5'd16;

	typedef enum logic {
		ITEM_TRANS,
		ITEM_EMIT
	} item_kind_t;

	typedef struct packed {
		item_kind_t                    kind;
		logic [LABEL_BITS-1:0]         from_lbl;
		logic [LABEL_BITS-1:0]         to_lbl;
		logic signed [PATH_BITS-1:0]   score;
		logic                          seq_end;
	} vsd_item_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ACS,
		ST_ACS_DRAIN,
		ST_UPDATE,
		ST_ADVANCE,
		ST_ARGMAX,
		ST_TB_RD,
		ST_TB_WR,
		ST_EM_RD,
		ST_EM_OUT
	} vsd_state_t;

	function automatic logic signed [PATH_BITS-1:0] sat_add(
		input logic signed [PATH_BITS-1:0] a,
		input logic signed [PATH_BITS-1:0] b
	);
		logic signed [PATH_BITS:0] s;
		s = {a[PATH_BITS-1], a} + {b[PATH_BITS-1], b};
		if (s[PATH_BITS] != s[PATH_BITS-1]) begin
			return s[PATH_BITS] ? {1'b1, {(PATH_BITS-1){1'b0}}}
			                    : {1'b0, {(PATH_BITS-1){1'b1}}};
		end
		return s[PATH_BITS-1:0];
	endfunction

endpackage

// ----- rtl/vsd_front.sv -----
module vsd_front
	import vsd_pkg::*;
#(
	parameter int MAX_LABELS = 16,
	parameter int SCORE_BITS = 24,
	parameter int LCW        = 5
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         mode,
	input  logic [LABEL_BITS-1:0]        from_label,
	input  logic [LABEL_BITS-1:0]        to_label,
	input  logic signed [SCORE_BITS-1:0] score,
	input  logic                         sequence_end,
	input  logic [LCW-1:0]               lc,
	input  logic                         clearing,
	output logic                         q_valid,
	input  logic                         q_ready,
	output vsd_item_t                    q_item
);

	vsd_item_t  entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       keep;
	logic       push;
	logic       pop;
	vsd_item_t  item;

	// Transitions outside the table and emissions for unused labels are dropped here.
	always_comb begin
		item.kind     = mode ? ITEM_EMIT : ITEM_TRANS;
		item.from_lbl = from_label;
		item.to_lbl   = to_label;
		item.score    = PATH_BITS'(score);
		item.seq_end  = sequence_end;
		if (mode) begin
			keep = (32'(to_label) < 32'(lc));
		end else begin
			keep = (32'(from_label) < 32'(MAX_LABELS)) && (32'(to_label) < 32'(MAX_LABELS));
		end
	end

	assign in_ready = (cnt_q != 2'd2) && !clearing;
	assign push     = in_valid && in_ready && keep;
	assign q_valid  = (cnt_q != 2'd0);
	assign pop      = q_valid && q_ready;
	assign q_item   = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= item;
		end
	end

endmodule

// ----- rtl/vsd_back.sv -----
module vsd_back
	import vsd_pkg::*;
#(
	parameter int MAX_LABELS    = 16,
	parameter int MAX_POSITIONS = 64,
	parameter int LCW           = 5
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [LCW-1:0]        lc,
	input  logic                  q_valid,
	output logic                  q_ready,
	input  vsd_item_t             q_item,
	output logic                  clearing,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [5:0]            position,
	output logic [LABEL_BITS-1:0] best_label,
	output logic                  last,
	output logic                  overflow
);

	localparam int LW  = $clog2(MAX_LABELS);
	localparam int PW  = $clog2(MAX_POSITIONS);
	localparam int CW  = $clog2(MAX_POSITIONS + 1);
	localparam int TN  = MAX_LABELS * MAX_LABELS;
	localparam int TAW = $clog2(TN);
	localparam int BN  = MAX_POSITIONS * MAX_LABELS;
	localparam int BAW = $clog2(BN);

	vsd_state_t state_q, state_d;

	logic signed [PATH_BITS-1:0] tt_mem [TN];
	logic [LW-1:0]               bp_mem [BN];
	logic [LW-1:0]               path_mem [MAX_POSITIONS];

	logic signed [PATH_BITS-1:0] cur_q  [MAX_LABELS];
	logic signed [PATH_BITS-1:0] prev_q [MAX_LABELS];

	vsd_item_t                   it_q;
	logic [TAW-1:0]              clr_q;
	logic [LW-1:0]               j_q;
	logic [LW-1:0]               j_s1;
	logic                        vld_s1;
	logic signed [PATH_BITS-1:0] prev_s1;
	logic signed [PATH_BITS-1:0] tt_rd_s1;
	logic signed [PATH_BITS-1:0] best_q;
	logic [LW-1:0]               arg_q;
	logic [CW-1:0]               pos_cnt_q;
	logic                        ovf_q;
	logic [PW-1:0]               t_q;
	logic [LW-1:0]               lbl_q;
	logic [LW-1:0]               bp_rd_q;
	logic [LW-1:0]               path_rd_q;
	logic                        o_valid_q;
	logic [5:0]                  o_pos_q;
	logic [LABEL_BITS-1:0]       o_lbl_q;
	logic                        o_last_q;
	logic                        o_ovf_q;

	logic [LW-1:0]               it_to;
	logic [LW-1:0]               lc_last;
	logic [PW-1:0]               n_last;
	logic                        complete;
	logic signed [PATH_BITS-1:0] cand;
	logic signed [PATH_BITS-1:0] upd_val;
	logic [LW-1:0]               am_sel;
	logic                        tt_we;
	logic [TAW-1:0]              tt_waddr;
	logic signed [PATH_BITS-1:0] tt_wdata;
	logic [TAW-1:0]              tt_raddr;
	logic                        out_free;

	assign it_to    = LW'(it_q.to_lbl);
	assign lc_last  = LW'(lc - LCW'(1));
	assign n_last   = PW'(pos_cnt_q - CW'(1));
	assign complete = (it_to == lc_last) || it_q.seq_end;
	assign cand     = sat_add(prev_s1, tt_rd_s1);
	assign upd_val  = (pos_cnt_q == '0) ? it_q.score : sat_add(best_q, it_q.score);
	assign am_sel   = ((j_q == '0) || (prev_q[j_q] > best_q)) ? j_q : arg_q;
	assign tt_raddr = TAW'(j_q) * TAW'(MAX_LABELS) + TAW'(it_to);
	assign out_free = !o_valid_q || out_ready;

	assign clearing   = (state_q == ST_CLEAR);
	assign out_valid  = o_valid_q;
	assign position   = o_pos_q;
	assign best_label = o_lbl_q;
	assign last       = o_last_q;
	assign overflow   = o_ovf_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == TAW'(TN - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (q_valid && (q_item.kind == ITEM_EMIT)) begin
					if (pos_cnt_q >= CW'(MAX_POSITIONS)) begin
						state_d = q_item.seq_end ? ST_ARGMAX : ST_IDLE;
					end else if (pos_cnt_q == '0) begin
						state_d = ST_UPDATE;
					end else begin
						state_d = ST_ACS;
					end
				end
			end
			ST_ACS: begin
				if (j_q == lc_last) begin
					state_d = ST_ACS_DRAIN;
				end
			end
			ST_ACS_DRAIN: state_d = ST_UPDATE;
			ST_UPDATE:    state_d = complete ? ST_ADVANCE : ST_IDLE;
			ST_ADVANCE:   state_d = it_q.seq_end ? ST_ARGMAX : ST_IDLE;
			ST_ARGMAX: begin
				if (j_q == lc_last) begin
					state_d = (n_last == '0) ? ST_EM_RD : ST_TB_RD;
				end
			end
			ST_TB_RD: state_d = ST_TB_WR;
			ST_TB_WR: state_d = (t_q == PW'(1)) ? ST_EM_RD : ST_TB_RD;
			ST_EM_RD: state_d = ST_EM_OUT;
			ST_EM_OUT: begin
				if (out_free) begin
					state_d = (t_q == n_last) ? ST_IDLE : ST_EM_RD;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		q_ready  = (state_q == ST_IDLE);
		tt_we    = 1'b0;
		tt_waddr = clr_q;
		tt_wdata = '0;
		case (state_q)
			ST_CLEAR: begin
				tt_we = 1'b1;
			end
			ST_IDLE: begin
				tt_we    = q_valid && (q_item.kind == ITEM_TRANS);
				tt_waddr = TAW'(LW'(q_item.from_lbl)) * TAW'(MAX_LABELS) + TAW'(LW'(q_item.to_lbl));
				tt_wdata = q_item.score;
			end
			default: begin
				tt_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_q     <= '0;
			pos_cnt_q <= '0;
			ovf_q     <= 1'b0;
			o_valid_q <= 1'b0;
			vld_s1    <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= (state_q == ST_ACS);
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + TAW'(1);
			end
			if ((state_q == ST_EM_OUT) && out_free) begin
				o_valid_q <= 1'b1;
			end else if (out_ready) begin
				o_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_valid && (q_item.kind == ITEM_EMIT) &&
					    (pos_cnt_q >= CW'(MAX_POSITIONS))) begin
						ovf_q <= 1'b1;
					end
				end
				ST_ADVANCE: begin
					pos_cnt_q <= pos_cnt_q + CW'(1);
				end
				ST_EM_OUT: begin
					if (out_free && (t_q == n_last)) begin
						pos_cnt_q <= '0;
						ovf_q     <= 1'b0;
					end
				end
				default: begin
					ovf_q <= ovf_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (tt_we) begin
			tt_mem[tt_waddr] <= tt_wdata;
		end
		tt_rd_s1 <= tt_mem[tt_raddr];
		prev_s1  <= prev_q[j_q];
		j_s1     <= j_q;
		bp_rd_q  <= bp_mem[BAW'(t_q) * BAW'(MAX_LABELS) + BAW'(lbl_q)];
		path_rd_q <= path_mem[t_q];

		if (vld_s1 && ((j_s1 == '0) || (cand > best_q))) begin
			best_q <= cand;
			arg_q  <= j_s1;
		end

		case (state_q)
			ST_IDLE: begin
				it_q <= q_item;
				j_q  <= '0;
			end
			ST_ACS: begin
				j_q <= j_q + LW'(1);
			end
			ST_UPDATE: begin
				cur_q[it_to] <= upd_val;
				if (pos_cnt_q != '0) begin
					bp_mem[BAW'(pos_cnt_q) * BAW'(MAX_LABELS) + BAW'(it_to)] <= arg_q;
				end
			end
			ST_ADVANCE: begin
				prev_q <= cur_q;
				j_q    <= '0;
			end
			ST_ARGMAX: begin
				best_q <= prev_q[am_sel];
				arg_q  <= am_sel;
				j_q    <= j_q + LW'(1);
				if (j_q == lc_last) begin
					path_mem[n_last] <= am_sel;
					lbl_q            <= am_sel;
					t_q              <= n_last;
				end
			end
			ST_TB_WR: begin
				lbl_q               <= bp_rd_q;
				path_mem[t_q - PW'(1)] <= bp_rd_q;
				t_q                 <= t_q - PW'(1);
			end
			ST_EM_OUT: begin
				if (out_free) begin
					o_pos_q  <= 6'(t_q);
					o_lbl_q  <= LABEL_BITS'(path_rd_q);
					o_last_q <= (t_q == n_last);
					o_ovf_q  <= ovf_q;
					t_q      <= t_q + PW'(1);
				end
			end
			default: begin
				lbl_q <= lbl_q;
			end
		endcase
	end

endmodule

// ----- rtl/viterbi_sequence_decoder_unit.sv -----
// Channel   Direction  Handshake               Payload
// in        input      in_valid / in_ready     mode, from_label, to_label, score, sequence_end
// out       output     out_valid / out_ready   position, best_label, last, overflow
// cfg       input      cfg_we                  cfg_wdata (label count)
//
// A transition is written into the table straight from the idle state. An emission is
// handled by the single add-compare-select unit that walks the predecessors, except at
// the first position; an emission that completes a position also advances the position.
// A sequence end adds the final search over the labels, a trace-back through the stored
// positions and the output of one result per position.
// After reset the transition table, all MAX_LABELS squared entries, is cleared; no request
// is taken meanwhile. A two-entry queue lets input requests arrive while results stall.
module viterbi_sequence_decoder_unit
	import vsd_pkg::*;
#(
	parameter int MAX_LABELS    = 16,
	parameter int MAX_POSITIONS = 64,
	parameter int SCORE_BITS    = 24
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [CFG_BITS-1:0]          cfg_wdata,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         mode,
	input  logic [LABEL_BITS-1:0]        from_label,
	input  logic [LABEL_BITS-1:0]        to_label,
	input  logic signed [SCORE_BITS-1:0] score,
	input  logic                         sequence_end,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [5:0]                   position,
	output logic [LABEL_BITS-1:0]        best_label,
	output logic                         last,
	output logic                         overflow
);

	localparam int LCW = $clog2(MAX_LABELS + 1);

	logic [CFG_BITS-1:0] label_count_q;
	logic [LCW-1:0]      lc;
	logic                q_valid;
	logic                q_ready;
	vsd_item_t           q_item;
	logic                clearing;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			label_count_q <= LABEL_COUNT_RESET;
		end else if (cfg_we) begin
			label_count_q <= cfg_wdata;
		end
	end

	always_comb begin
		if (label_count_q == '0) begin
			lc = LCW'(1);
		end else if (32'(label_count_q) > 32'(MAX_LABELS)) begin
			lc = LCW'(MAX_LABELS);
		end else begin
			lc = LCW'(label_count_q);
		end
	end

	vsd_front #(
		.MAX_LABELS (MAX_LABELS),
		.SCORE_BITS (SCORE_BITS),
		.LCW        (LCW)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.mode         (mode),
		.from_label   (from_label),
		.to_label     (to_label),
		.score        (score),
		.sequence_end (sequence_end),
		.lc           (lc),
		.clearing     (clearing),
		.q_valid      (q_valid),
		.q_ready      (q_ready),
		.q_item       (q_item)
	);

	vsd_back #(
		.MAX_LABELS    (MAX_LABELS),
		.MAX_POSITIONS (MAX_POSITIONS),
		.LCW           (LCW)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.lc         (lc),
		.q_valid    (q_valid),
		.q_ready    (q_ready),
		.q_item     (q_item),
		.clearing   (clearing),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.position   (position),
		.best_label (best_label),
		.last       (last),
		.overflow   (overflow)
	);

	// No request may enter while the transition table is being cleared.
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !in_ready)
		else $error("input accepted during table clear");

	// No result can exist before the clearing pass has finished.
	a_no_result_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !out_valid)
		else $error("result presented during table clear");

	// The queue is never drained by the back end while it is clearing.
	a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !q_ready)
		else $error("queue popped during table clear");

endmodule
